[rtl/hybrid_logical_clock_tid_assert.svh]
// Assertion macros for the hybrid logical clock block.
// Included by the top level; no other dependencies.
`ifndef HYBRID_LOGICAL_CLOCK_TID_ASSERT_SVH
`define HYBRID_LOGICAL_CLOCK_TID_ASSERT_SVH

// Clocked check, disabled while reset is high.
`define HLC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define HLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hlc_pkg.sv]
// Shared types and constants for the hybrid logical clock block.
// No dependencies.
package hlc_pkg;

   localparam int CLOCK_BITS           = 64;
   localparam int NOW_BITS             = 48;
   localparam int SEQ_BITS             = 16;
   localparam int FUNC_BITS            = 2;
   localparam int DEFAULT_LOGICAL_BITS = 16;

   // Id keeps the clock's upper 48 bits; sequence fills the low 16.
   localparam logic [CLOCK_BITS-1:0] ID_TIME_MASK = 64'hFFFF_FFFF_FFFF_0000;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_MERGE = 2'd1,
      FUNC_ISSUE = 2'd2,
      FUNC_HOLD  = 2'd3
   } func_type;

   typedef struct packed {
      func_type               func;
      logic [NOW_BITS-1:0]    now_us;
      logic [CLOCK_BITS-1:0]  remote_stamp;
   } item_type;

   typedef struct packed {
      logic [CLOCK_BITS-1:0]  txn_id;
      logic [CLOCK_BITS-1:0]  clock_value;
   } result_type;

endpackage

[rtl/hlc_update.sv]
// Next-state logic of the hybrid logical clock: tick, merge, id issue and hold.
// Depends on hlc_pkg.
module hlc_update #(
   parameter int LOGICAL_BITS = hlc_pkg::DEFAULT_LOGICAL_BITS
) (
   input  hlc_pkg::item_type                   item,
   input  logic [hlc_pkg::CLOCK_BITS-1:0]      clock_cur,
   input  logic [hlc_pkg::SEQ_BITS-1:0]        seq_cur,
   output logic [hlc_pkg::CLOCK_BITS-1:0]      clock_next,
   output logic [hlc_pkg::SEQ_BITS-1:0]        seq_next,
   output hlc_pkg::result_type                 result
);
   import hlc_pkg::*;

   localparam int PHYS_BITS = CLOCK_BITS - LOGICAL_BITS;

   logic [PHYS_BITS-1:0]    now_p;
   logic [PHYS_BITS-1:0]    cur_p;
   logic [PHYS_BITS-1:0]    rem_p;
   logic [PHYS_BITS-1:0]    max_p;
   logic [LOGICAL_BITS-1:0] cur_l;
   logic [LOGICAL_BITS-1:0] rem_l;
   logic [LOGICAL_BITS-1:0] max_l;
   logic [CLOCK_BITS-1:0]   tick_clock;
   logic [CLOCK_BITS-1:0]   merge_clock;
   logic [LOGICAL_BITS-1:0] merge_l;
   logic                    cur_top;
   logic                    rem_top;

   // Now is fitted to the physical width (truncated or zero extended).
   assign now_p = PHYS_BITS'(item.now_us);
   assign cur_p = clock_cur[CLOCK_BITS-1:LOGICAL_BITS];
   assign cur_l = clock_cur[LOGICAL_BITS-1:0];
   assign rem_p = item.remote_stamp[CLOCK_BITS-1:LOGICAL_BITS];
   assign rem_l = item.remote_stamp[LOGICAL_BITS-1:0];

   assign tick_clock = (now_p > cur_p) ? {now_p, {LOGICAL_BITS{1'b0}}}
                                       : {cur_p, cur_l + LOGICAL_BITS'(1)};

   // Merge: largest physical part wins, logical follows the tie pattern.
   always_comb begin
      max_p = now_p;
      if (cur_p > max_p) max_p = cur_p;
      if (rem_p > max_p) max_p = rem_p;
   end

   assign cur_top = (max_p == cur_p);
   assign rem_top = (max_p == rem_p);
   assign max_l   = (cur_l > rem_l) ? cur_l : rem_l;

   always_comb begin
      priority if (cur_top && rem_top) merge_l = max_l + LOGICAL_BITS'(1);
      else if (cur_top)                merge_l = cur_l + LOGICAL_BITS'(1);
      else if (rem_top)                merge_l = rem_l + LOGICAL_BITS'(1);
      else                             merge_l = '0;
   end

   assign merge_clock = {max_p, merge_l};

   always_comb begin
      clock_next         = clock_cur;
      seq_next           = seq_cur;
      result.txn_id      = '0;
      unique case (item.func)
         FUNC_TICK: begin
            clock_next = tick_clock;
         end
         FUNC_MERGE: begin
            clock_next = merge_clock;
         end
         FUNC_ISSUE: begin
            clock_next    = tick_clock;
            seq_next      = seq_cur + SEQ_BITS'(1);
            result.txn_id = (tick_clock & ID_TIME_MASK) | CLOCK_BITS'(seq_cur);
         end
         FUNC_HOLD: begin
            clock_next = clock_cur;
         end
      endcase
      result.clock_value = clock_next;
   end

endmodule

[rtl/hybrid_logical_clock_tid.sv]
// Top level of the hybrid logical clock with transaction id issue.
// Depends on hlc_pkg, hlc_update and hybrid_logical_clock_tid_assert.svh.
//
// Use:
//   req_* carries one event per transfer: req_tuser is the event kind
//   (0 local tick, 1 merge remote stamp, 2 tick and issue id, 3 no change),
//   req_tdata the current time in microseconds and the remote stamp.
//   rsp_* returns exactly one transfer per event: the clock after the event
//   and, for an id event, the transaction id (zero otherwise).
//   Path: an accepted request passes through an input register, then the
//   update into the result register, which drives rsp_tvalid.
//   Throughput: one event per cycle while rsp_tready stays high. The clock
//   and sequence registers are updated in the same cycle the event moves
//   into the result register, so the next event sees them at once.
//   Stall: when rsp_tready is low the result holds, the staged request
//   waits, and req_tready drops once both stages are full.
//   Reset (synchronous, active high): clock and sequence clear to zero and
//   both stages empty.
`include "hybrid_logical_clock_tid_assert.svh"

module hybrid_logical_clock_tid #(
   parameter int LOGICAL_BITS = hlc_pkg::DEFAULT_LOGICAL_BITS
) (
   input  logic          clock,
   input  logic          reset,
   // request: tuser[1:0] = func
   //          tdata[47:0] = now_us, tdata[111:48] = remote_stamp
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,
   input  logic [111:0]  req_tdata,
   // response: tdata[63:0] = clock_value, tdata[127:64] = txn_id
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata
);
   import hlc_pkg::*;

   // input stage
   logic                   in_valid_ff, in_valid_in;
   item_type               in_item_ff;
   item_type               req_item;

   // result stage
   logic                   out_valid_ff, out_valid_in;
   result_type             out_result_ff;

   // clock state
   logic [CLOCK_BITS-1:0]  clock_ff, clock_in;
   logic [SEQ_BITS-1:0]    seq_ff, seq_in;

   logic [CLOCK_BITS-1:0]  upd_clock;
   logic [SEQ_BITS-1:0]    upd_seq;
   result_type             upd_result;

   logic                   advance;
   logic                   req_take;

   assign req_item.func         = func_type'(req_tuser);
   assign req_item.now_us       = req_tdata[NOW_BITS-1:0];
   assign req_item.remote_stamp = req_tdata[NOW_BITS+CLOCK_BITS-1:NOW_BITS];

   // Staged event moves on when the result slot is free or being drained.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   hlc_update #(
      .LOGICAL_BITS (LOGICAL_BITS)
   ) u_update (
      .item       (in_item_ff),
      .clock_cur  (clock_ff),
      .seq_cur    (seq_ff),
      .clock_next (upd_clock),
      .seq_next   (upd_seq),
      .result     (upd_result)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      clock_in     = advance ? upd_clock : clock_ff;
      seq_in       = advance ? upd_seq : seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         clock_ff     <= '0;
         seq_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         clock_ff     <= clock_in;
         seq_ff       <= seq_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_result_ff <= upd_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_result_ff.txn_id, out_result_ff.clock_value};

   // Physical part never moves backward outside reset.
   `HLC_ASSERT(a_phys_monotone, clock, reset,
      !$past(reset) |-> (clock_ff[CLOCK_BITS-1:LOGICAL_BITS] >=
                         $past(clock_ff[CLOCK_BITS-1:LOGICAL_BITS])),
      "physical part of clock went backward")

   // Sequence only moves on an id event leaving the input stage.
   `HLC_ASSERT(a_seq_on_issue, clock, reset,
      (!$past(reset) && (seq_ff != $past(seq_ff))) |->
         ($past(advance) && ($past(in_item_ff.func) == FUNC_ISSUE)),
      "sequence changed without an id event")

   // A nonzero id carries the reported clock's upper 48 bits.
   `HLC_ASSERT(a_id_matches_clock, clock, reset,
      (rsp_tvalid && (out_result_ff.txn_id != '0)) |->
         ((out_result_ff.txn_id & ID_TIME_MASK) ==
          (out_result_ff.clock_value & ID_TIME_MASK)),
      "transaction id does not match clock value")

endmodule

[dv/hybrid_logical_clock_tid_test.sv]
// Testbench for hybrid_logical_clock_tid: random and directed events checked against
// an in-bench clock/sequence predictor. Depends on hlc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module hybrid_logical_clock_tid_test;
   import hlc_pkg::*;

   // Split of the 64-bit stamp; the block is built with its default width.
   localparam int              LB        = DEFAULT_LOGICAL_BITS;
   localparam logic [63:0]     LOG_MASK  = (64'd1 << LB) - 64'd1;
   localparam logic [63:0]     PHYS_MASK = (64'd1 << (64 - LB)) - 64'd1;
   localparam int              RAND_EVENTS = 1527;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [1:0]    req_tuser  = '0;     // [1:0] func
   logic [111:0]  req_tdata  = '0;     // [47:0] now_us, [111:48] remote_stamp
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;           // [63:0] clock_value, [127:64] txn_id

   // High during one stretch of the random part: no idling on either side.
   logic          steady     = 1'b0;

   // Predicts the clock and sequence registers and holds the expected
   // responses in arrival order.
   class hlc_scoreboard;
      logic [63:0]  clock_state;
      logic [15:0]  seq_state;
      result_type   pending[$];
      int           errors;
      int           checked;
      int           per_func[4];

      function new();
         clock_state = '0;
         seq_state   = '0;
         errors      = 0;
         checked     = 0;
         per_func    = '{default: 0};
      endfunction

      task report_mismatch(input string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         errors++;
      endtask

      // Called once per accepted request transfer.
      function void note_request(input func_type f, input logic [47:0] now_raw,
                                 input logic [63:0] remote);
         logic [63:0] now, cp, cl, rp, rl, np, nl, id;
         result_type  r;
         now = {16'd0, now_raw} & PHYS_MASK;
         cp  = clock_state >> LB;
         cl  = clock_state & LOG_MASK;
         rp  = remote >> LB;
         rl  = remote & LOG_MASK;
         np  = cp;
         nl  = cl;
         id  = '0;
         case (f)
            FUNC_TICK, FUNC_ISSUE: begin
               if (now > cp) begin
                  np = now;
                  nl = '0;
               end else begin
                  nl = cl + 64'd1;
               end
            end
            FUNC_MERGE: begin
               np = now;
               if (cp > np) np = cp;
               if (rp > np) np = rp;
               if (np == cp && np == rp) nl = ((cl > rl) ? cl : rl) + 64'd1;
               else if (np == cp)        nl = cl + 64'd1;
               else if (np == rp)        nl = rl + 64'd1;
               else                      nl = '0;
            end
            default: ;  // hold: nothing moves
         endcase
         clock_state = ((np & PHYS_MASK) << LB) | (nl & LOG_MASK);
         if (f == FUNC_ISSUE) begin
            // id takes the sequence value from before this event
            id        = (clock_state & ID_TIME_MASK) | {48'd0, seq_state};
            seq_state = seq_state + 16'd1;
         end
         r.clock_value = clock_state;
         r.txn_id      = id;
         pending.insert(pending.size(), r);
         per_func[f]++;
      endfunction

      // Called once per accepted response transfer.
      task check_response(input logic [127:0] data);
         result_type got, want;
         got = result_type'(data);
         if (pending.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected, data %h", data));
         end else begin
            want = pending.pop_front();
            checked++;
            if (got.clock_value !== want.clock_value)
               report_mismatch($sformatf("clock_value %h, expected %h",
                                         got.clock_value, want.clock_value));
            if (got.txn_id !== want.txn_id)
               report_mismatch($sformatf("txn_id %h, expected %h",
                                         got.txn_id, want.txn_id));
         end
      endtask
   endclass

   hlc_scoreboard sb = new();

   hybrid_logical_clock_tid dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Response side: ready drops in about a third of the cycles, except
   // during the steady stretch. Driven on the falling edge.
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 35);
   end

   // Response transfers are sampled on the rising edge, before the block's
   // registers move.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // Stamp layout: physical part above the logical part.
   function automatic logic [63:0] stamp(input logic [63:0] phys, input logic [63:0] lg);
      return ((phys & PHYS_MASK) << LB) | (lg & LOG_MASK);
   endfunction

   // Presents one event, possibly after some idle cycles, and returns at the
   // falling edge after its transfer. Entered at a falling edge.
   task send_event(input func_type f, input logic [47:0] now, input logic [63:0] remote);
      while (!steady && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {remote, now};
      do @(posedge clock); while (!req_tready);
      sb.note_request(f, now, remote);
      @(negedge clock);
   endtask

   initial begin
      logic [63:0] p, rp, rl;
      logic [63:0] remote;
      logic [47:0] now;
      func_type    f;
      int          pick;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: tick rules, every merge branch, logical wrap, hold and
      // ignored fields at their extremes.
      send_event(FUNC_TICK,  48'd0, '1);               // now equals zero clock
      send_event(FUNC_TICK,  48'd5, '0);               // now ahead
      send_event(FUNC_TICK,  48'd5, '0);               // now equal
      send_event(FUNC_TICK,  48'd3, '0);               // now behind
      send_event(FUNC_ISSUE, 48'd5, '1);               // first id, sequence 0
      send_event(FUNC_ISSUE, 48'd6, '0);               // id on a fresh physical time
      send_event(FUNC_MERGE, 48'd6, stamp(64'd6, 64'd10));   // all three equal
      send_event(FUNC_MERGE, 48'd7, stamp(64'd6, 64'd40));   // now alone largest
      send_event(FUNC_MERGE, 48'd1, stamp(64'd9, LOG_MASK));         // remote only, wraps
      send_event(FUNC_MERGE, 48'd9, stamp(64'd9, LOG_MASK - 64'd1)); // to all-ones logical
      send_event(FUNC_TICK,  48'd4, '0);               // local logical wraps
      send_event(FUNC_MERGE, 48'd2, stamp(64'd3, 64'd5));    // local only
      send_event(FUNC_MERGE, 48'd9, stamp(64'd9, 64'd0));    // both equal, local logical larger
      send_event(FUNC_MERGE, 48'd10, stamp(64'd10, 64'd7));  // now ties remote, local behind
      send_event(FUNC_HOLD,  '1, '1);                  // no change
      send_event(FUNC_HOLD,  '0, '0);
      send_event(FUNC_ISSUE, 48'd3, '0);
      send_event(FUNC_MERGE, 48'd0, '0);

      // Random: times mostly track the clock so that ties, small steps and
      // logical carries keep happening; a few wild values jump it ahead.
      for (int i = 0; i < RAND_EVENTS; i++) begin
         steady = (i >= 500 && i < 800);
         p    = sb.clock_state >> LB;
         pick = $urandom_range(0, 99);
         f    = (pick < 30) ? FUNC_TICK : (pick < 60) ? FUNC_MERGE :
                (pick < 95) ? FUNC_ISSUE : FUNC_HOLD;

         pick = $urandom_range(0, 99);
         if (pick < 4)       now = 48'({$urandom, $urandom});
         else if (pick < 55) now = 48'(p + 64'($urandom_range(1, 3)));
         else if (pick < 80) now = 48'(p);
         else                now = 48'((p > 5) ? p - 64'($urandom_range(0, 5)) : p);

         remote = {$urandom, $urandom};
         if (f == FUNC_MERGE && $urandom_range(0, 99) >= 3) begin
            rp = p + 64'($urandom_range(0, 4));
            rp = (rp > 1) ? rp - 64'd2 : rp;
            case ($urandom_range(0, 3))
               0:       rl = 64'($urandom) & LOG_MASK;
               1:       rl = LOG_MASK;
               2:       rl = LOG_MASK - 64'd1;
               default: rl = (sb.clock_state + 64'($urandom_range(0, 2)) - 64'd1) & LOG_MASK;
            endcase
            remote = stamp(rp, rl);
         end
         send_event(f, now, remote);
      end
      steady = 1'b0;

      // Top of the physical range last, since the clock cannot come back.
      send_event(FUNC_ISSUE, '1, '0);
      send_event(FUNC_TICK,  '1, '0);
      send_event(FUNC_MERGE, '1, '1);                  // all equal, logical wraps
      send_event(FUNC_ISSUE, '0, '1);
      send_event(FUNC_HOLD,  '1, '1);
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.pending.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending.size()));

      $display("Ran %0d events: %0d ticks, %0d merges, %0d id issues, %0d holds.",
               sb.checked, sb.per_func[FUNC_TICK], sb.per_func[FUNC_MERGE],
               sb.per_func[FUNC_ISSUE], sb.per_func[FUNC_HOLD]);
      $display("Both sides stalled at random, with one stretch of back-to-back transfers.");
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Timeout: %0d responses outstanding", sb.pending.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
